### sv/mie_pkg.sv
// Shared types and constants for the modular inverse unit.
`default_nettype none

package mie_pkg;

	// Operand and result width
	localparam int MIE_WIDTH = 32;
	// Counter width for the divisor alignment shift
	localparam int MIE_CNT_W = $clog2(MIE_WIDTH);

	// Request item
	typedef struct packed {
		logic [MIE_WIDTH-1:0] value;
		logic [MIE_WIDTH-1:0] modulus;
	} mie_req_t;

	// Result item
	typedef struct packed {
		logic [MIE_WIDTH-1:0] divisor;
		logic [MIE_WIDTH-1:0] inverse;
		logic                 has_inverse;
	} mie_rsp_t;

endpackage

`default_nettype wire

### sv/modular_inverse_ext_euclid_unit.sv
// Modular inverse and gcd by the extended Euclidean algorithm, one shared shift-subtract divider.
//
// Pulse start with a request while busy is low; busy rises the next cycle and stays high
// until the result is presented. The result sits on rsp for exactly one cycle, flagged by
// done, and must be captured then: there is no way to hold it. Each Euclid step runs on one
// shift-subtract unit: the divisor is first shifted up to the dividend, then restoring
// subtract steps, one per quotient bit, produce the remainder and fold the quotient into the
// coefficient product, then the coefficient pair is updated; the step that leaves a zero
// remainder skips the update and goes on to present the result. A request with a zero
// operand leaves busy low, and done follows in the next cycle with all result fields zero.
`default_nettype none

module modular_inverse_ext_euclid_unit
	import mie_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire mie_req_t req,
	output logic          done,
	output mie_rsp_t      rsp
);

	localparam int W  = MIE_WIDTH;
	localparam int CW = MIE_CNT_W;

	// Sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ALIGN  = 3'd1;
	localparam logic [2:0] ST_REDUCE = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]    state_q;
	logic [W-1:0]  m_q;      // modulus
	logic [W-1:0]  r_q;      // current divisor (previous remainder)
	logic [W-1:0]  rm_q;     // running dividend / remainder
	logic [W-1:0]  d_q;      // shifted divisor
	logic [CW-1:0] cnt_q;    // alignment shift count
	logic [W-1:0]  p_q;      // quotient times v, built MSB first
	logic [W-1:0]  u_mag_q;
	logic          u_neg_q;
	logic [W-1:0]  v_mag_q;
	logic          v_neg_q;
	logic          done_q;
	mie_rsp_t      rsp_q;

	// Shared subtractor for the restoring divide step
	logic [W:0]   div_diff;
	logic         div_ge;
	logic [W-1:0] rm_next;
	logic [W-1:0] p_next;
	logic         align_ok;

	always_comb begin
		div_diff = {1'b0, rm_q} - {1'b0, d_q};
		div_ge   = ~div_diff[W];
		rm_next  = div_ge ? div_diff[W-1:0] : rm_q;
		p_next   = {p_q[W-2:0], 1'b0} + (div_ge ? v_mag_q : '0);
		align_ok = ~d_q[W-1] && ({d_q, 1'b0} <= {1'b0, rm_q});
	end

	// Coefficient step: t = u - q*v in sign and magnitude
	logic [W:0]   coef_diff;
	logic [W-1:0] t_mag;
	logic         t_neg;
	logic         p_neg;

	always_comb begin
		p_neg     = ~v_neg_q;
		coef_diff = {1'b0, u_mag_q} - {1'b0, p_q};
		if (u_neg_q == p_neg) begin
			t_mag = u_mag_q + p_q;
			t_neg = u_neg_q;
		end else if (!coef_diff[W]) begin
			t_mag = coef_diff[W-1:0];
			t_neg = u_neg_q;
		end else begin
			t_mag = p_q - u_mag_q;
			t_neg = p_neg;
		end
		if (t_mag == '0) begin
			t_neg = 1'b0;
		end
	end

	// Final inverse: fold a non-positive coefficient back into range
	logic [W-1:0] inv_val;

	always_comb begin
		if (!v_neg_q && v_mag_q != '0) begin
			inv_val = v_mag_q;
		end else begin
			inv_val = m_q - v_mag_q;
		end
	end

	// Sequencer state and done strobe registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (req.value == '0 || req.modulus == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_ALIGN;
						end
					end
				end
				ST_ALIGN: begin
					if (!align_ok) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (cnt_q == '0) begin
						state_q <= (rm_next == '0) ? ST_FINISH : ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_ALIGN;
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				// Load a new item; a zero operand answers with all zeros at once
				rsp_q   <= '0;
				rm_q    <= req.value;
				r_q     <= req.modulus;
				d_q     <= req.modulus;
				m_q     <= req.modulus;
				cnt_q   <= '0;
				p_q     <= '0;
				u_mag_q <= W'(1);
				u_neg_q <= 1'b0;
				v_mag_q <= '0;
				v_neg_q <= 1'b0;
			end
			ST_ALIGN: begin
				// Shift the divisor up while it still fits under the dividend
				if (align_ok) begin
					d_q   <= {d_q[W-2:0], 1'b0};
					cnt_q <= cnt_q + CW'(1);
				end
			end
			ST_REDUCE: begin
				// One quotient bit per cycle, folded into the product
				rm_q <= rm_next;
				p_q  <= p_next;
				d_q  <= {1'b0, d_q[W-1:1]};
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			ST_UPDATE: begin
				// Advance the remainder pair and the coefficient pair
				u_mag_q <= v_mag_q;
				u_neg_q <= v_neg_q;
				v_mag_q <= t_mag;
				v_neg_q <= t_neg;
				rm_q    <= r_q;
				r_q     <= rm_q;
				d_q     <= rm_q;
				p_q     <= '0;
				cnt_q   <= '0;
			end
			ST_FINISH: begin
				// Present gcd and, when it is one, the inverse
				rsp_q.divisor <= r_q;
				if (r_q == W'(1)) begin
					rsp_q.inverse     <= inv_val;
					rsp_q.has_inverse <= 1'b1;
				end else begin
					rsp_q.inverse     <= '0;
					rsp_q.has_inverse <= 1'b0;
				end
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

### tb/modular_inverse_checker.sv
// Checker for the modular inverse unit: predicts each result and compares it with the block's.
module modular_inverse_checker
	import mie_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  mie_req_t req,
	input  logic     done,
	input  mie_rsp_t rsp,
	output int       fails,
	output int       owed,
	output int       checked,
	output int       invertible
);
	localparam int W = MIE_WIDTH;

	// Bezout coefficient of the value, kept as sign and magnitude
	typedef struct packed {
		logic         neg;
		logic [W-1:0] mag;
	} sm_coef_t;

	mie_rsp_t owed_rsp[$];
	int       nfail = 0;
	int       nchecked = 0;
	int       ninv = 0;

	// Next coefficient: (prev - quot*cur) with truncating remainder by the modulus
	function automatic sm_coef_t reduce_step(sm_coef_t prev, sm_coef_t cur,
			logic [W-1:0] quot, logic [W-1:0] modl);
		logic [2*W-1:0] wide_q;
		logic [2*W-1:0] wide_v;
		logic [2*W-1:0] wide_p;
		logic [W-1:0]   prod;
		logic           prod_neg;
		sm_coef_t       nxt;
		wide_q = {{W{1'b0}}, quot};
		wide_v = {{W{1'b0}}, cur.mag};
		wide_p = wide_q * wide_v;
		prod = wide_p[W-1:0];
		prod_neg = !cur.neg;
		if (prod == '0) begin
			nxt = prev;
		end else if (prev.neg == prod_neg) begin
			nxt.mag = prev.mag + prod;
			nxt.neg = prev.neg;
		end else if (prev.mag >= prod) begin
			nxt.mag = prev.mag - prod;
			nxt.neg = prev.neg;
		end else begin
			nxt.mag = prod - prev.mag;
			nxt.neg = prod_neg;
		end
		nxt.mag = nxt.mag % modl;
		if (nxt.mag == '0)
			nxt.neg = 1'b0;
		return nxt;
	endfunction

	// Run Euclid on the request and form divisor and inverse
	function automatic mie_rsp_t inverse_result(mie_req_t item);
		logic [W-1:0] g;
		logic [W-1:0] r;
		logic [W-1:0] q;
		logic [W-1:0] rem;
		sm_coef_t     u;
		sm_coef_t     v;
		sm_coef_t     t;
		mie_rsp_t     res;
		res = '0;
		if (item.value == '0 || item.modulus == '0)
			return res;
		g = item.value;
		r = item.modulus;
		u.neg = 1'b0;
		u.mag = W'(1);
		v = '0;
		q = g / r;
		rem = g % r;
		while (rem != '0) begin
			t = reduce_step(u, v, q, item.modulus);
			u = v;
			v = t;
			g = r;
			r = rem;
			q = g / r;
			rem = g % r;
		end
		res.divisor = r;
		if (r == W'(1)) begin
			res.inverse = (!v.neg && v.mag != '0) ? v.mag : item.modulus - v.mag;
			res.has_inverse = 1'b1;
		end
		return res;
	endfunction

	// Compare results first, then queue the prediction for a newly accepted item
	always @(posedge clk) begin
		mie_rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (owed_rsp.size() == 0) begin
					$error("result with no item outstanding: divisor %h inverse %h has_inverse %b",
						rsp.divisor, rsp.inverse, rsp.has_inverse);
					nfail++;
				end else begin
					want = owed_rsp.pop_front();
					if (rsp.divisor !== want.divisor) begin
						$error("divisor: expected %h, got %h", want.divisor, rsp.divisor);
						nfail++;
					end
					if (rsp.inverse !== want.inverse) begin
						$error("inverse: expected %h, got %h", want.inverse, rsp.inverse);
						nfail++;
					end
					if (rsp.has_inverse !== want.has_inverse) begin
						$error("has_inverse: expected %b, got %b", want.has_inverse,
							rsp.has_inverse);
						nfail++;
					end
					nchecked++;
					if (want.has_inverse)
						ninv++;
				end
			end
			if (start && !busy)
				owed_rsp.push_back(inverse_result(req));
		end
		fails <= nfail;
		owed <= owed_rsp.size();
		checked <= nchecked;
		invertible <= ninv;
	end

endmodule

### tb/modular_inverse_ext_euclid_unit_test.sv
// Stimulus and verdict for the modular inverse unit.
module modular_inverse_ext_euclid_unit_test;
	import mie_pkg::*;

	localparam int           W = MIE_WIDTH;
	localparam logic [W-1:0] ALL_ONES = '1;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	mie_req_t req;
	mie_rsp_t rsp;
	int       fails;
	int       owed;
	int       checked;
	int       invertible;
	int       sent = 0;
	bit       quiet = 1'b0;

	modular_inverse_ext_euclid_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	modular_inverse_checker scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.fails(fails),
		.owed(owed),
		.checked(checked),
		.invertible(invertible)
	);

	always #2 clk = ~clk;

	// Bound the run in case the block hangs
	initial begin
		#8_000_000;
		$display("simulation failed");
		$finish;
	end

	// Offer one item, with an occasional idle gap first; hold it until busy is low
	task automatic issue(input logic [W-1:0] value, input logic [W-1:0] modulus);
		mie_req_t item;
		item.value = value;
		item.modulus = modulus;
		if (!quiet && $urandom_range(0, 99) < 17) begin
			// Drop start, wait until the block is ready and let it sit idle for a random gap
			start <= 1'b0;
			do @(posedge clk); while (busy);
			repeat ($urandom_range(0, 6)) @(posedge clk);
		end
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	initial begin
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] c;
		logic [W-1:0] f;
		int           sel;
		int           n;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero operands
		issue(0, 0);
		issue(0, 5);
		issue(5, 0);
		issue(ALL_ONES, 0);
		issue(0, ALL_ONES);
		// Modulus one
		issue(1, 1);
		issue(7, 1);
		issue(ALL_ONES, 1);
		// Small inverses and common factors
		issue(3, 7);
		issue(10, 7);
		issue(6, 9);
		issue(13, 13);
		issue(2, 4);
		issue(1, 2);
		// Extremes of the fields
		issue(ALL_ONES, ALL_ONES);
		issue(ALL_ONES, ALL_ONES - 1);
		issue(ALL_ONES - 1, ALL_ONES);
		issue(1, ALL_ONES);
		issue(2, ALL_ONES);
		issue(ALL_ONES, 2);
		issue(32'h8000_0000, 32'h7FFF_FFFF);
		issue(32'h5555_5555, 32'hAAAA_AAAA);
		// Consecutive Fibonacci numbers take the most Euclid steps
		issue(32'd2971215073, 32'd1836311903);
		issue(32'd1836311903, 32'd2971215073);

		// Random operands of several shapes; one stretch runs without idle gaps
		for (int i = 0; i < 1200; i++) begin
			quiet = (i >= 450 && i < 650);
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				a = $urandom;
				b = $urandom;
			end else if (sel < 50) begin
				a = $urandom;
				b = $urandom_range(1, 1000);
			end else if (sel < 62) begin
				f = $urandom_range(2, 1000);
				a = f * $urandom_range(1, 4_000_000);
				b = f * $urandom_range(1, 4_000_000);
			end else if (sel < 70) begin
				a = $urandom_range(0, 12);
				b = $urandom_range(0, 12);
			end else if (sel < 76) begin
				n = $urandom_range(1, 45);
				a = 1;
				b = 1;
				repeat (n) begin
					c = a + b;
					a = b;
					b = c;
				end
				if ($urandom_range(0, 1)) begin
					c = a;
					a = b;
					b = c;
				end
			end else if (sel < 82) begin
				a = $urandom;
				b = $urandom;
				case ($urandom_range(0, 3))
					0: b = 1;
					1: b = ALL_ONES;
					2: a = 1;
					default: a = ALL_ONES;
				endcase
			end else if (sel < 90) begin
				b = $urandom;
				a = b * $urandom_range(1, 3);
			end else begin
				a = 1;
				a = a << $urandom_range(0, W - 1);
				b = $urandom | 32'h8000_0000;
				if ($urandom_range(0, 1)) begin
					c = a;
					a = b;
					b = c;
				end
			end
			issue(a, b);
		end
		start <= 1'b0;

		// Drain the outstanding results, then allow for stray strobes
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("items issued %0d, results checked %0d, %0d of them with an inverse",
			sent, checked, invertible);
		$display("operands: zero, one, field extremes, shared factors, Fibonacci pairs, powers of two");
		if (fails == 0 && owed == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### files.f
sv/mie_pkg.sv
sv/modular_inverse_ext_euclid_unit.sv
tb/modular_inverse_checker.sv
tb/modular_inverse_ext_euclid_unit_test.sv
